[rtl/iss_pkg.sv]
// Shared types and constants for the insertion sorted store.
package iss_pkg;

  localparam int unsigned ISS_DEPTH_DEF = 256;
  localparam int unsigned ISS_DATA_W    = 32;

  typedef enum logic [0:0] {
    ISS_OP_PUSH = 1'b0,
    ISS_OP_POP  = 1'b1
  } iss_op_t;

  typedef enum logic [1:0] {
    ISS_ST_OK    = 2'd0,
    ISS_ST_FULL  = 2'd1,
    ISS_ST_EMPTY = 2'd2
  } iss_status_t;

  typedef struct packed {
    logic                         op;
    logic signed [ISS_DATA_W-1:0] value;
  } iss_in_req_t;

  typedef struct packed {
    logic signed [ISS_DATA_W-1:0] sorted_value;
    logic                         last;
    logic [1:0]                   status;
  } iss_out_req_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                         push;
    logic                         pop;
    logic signed [ISS_DATA_W-1:0] value;
  } iss_cmd_t;

endpackage

[rtl/iss_cell.sv]
// One place of the sorted chain: holds a value and its occupancy bit.
module iss_cell (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  iss_pkg::iss_cmd_t                     cmd,
  input  logic signed [iss_pkg::ISS_DATA_W-1:0] left_val,
  input  logic                                  left_occ,
  input  logic                                  left_gt,
  input  logic signed [iss_pkg::ISS_DATA_W-1:0] right_val,
  input  logic                                  right_occ,
  output logic signed [iss_pkg::ISS_DATA_W-1:0] val,
  output logic                                  occ,
  output logic                                  gt
);
  import iss_pkg::*;

  logic signed [ISS_DATA_W-1:0] val_r, val_nxt;
  logic                         occ_r, occ_nxt;

  // This place holds a value strictly greater than the one being pushed.
  assign gt  = occ_r && (val_r > cmd.value);
  assign val = val_r;
  assign occ = occ_r;

  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    if (cmd.pop) begin
      val_nxt = right_val;
      occ_nxt = right_occ;
    end else if (cmd.push) begin
      occ_nxt = occ_r | left_occ;
      if (left_gt) begin
        val_nxt = left_val;
      end else if (gt || !occ_r) begin
        val_nxt = cmd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

endmodule

[rtl/insertion_sorted_store_core.sv]
// Top level of the insertion sorted store: a chain of sorting cells and the result register.
//
// Usage: each input request carries an op and a signed 32-bit value. A push
// inserts the value into an ascending list held in a chain of DEPTH cells;
// entries greater than it move up one place, and equal values keep their
// arrival order. A pop removes the smallest entry and returns it, with last
// set when the store became empty. Every request yields exactly one result
// request with a status: ok, push dropped because the store was full, or pop
// while empty. Non-pop results carry a zero value and a clear last flag.
// The result is registered: out_valid rises in the cycle after acceptance.
// Throughput is one request per cycle while in_stall is low: every cell
// compares the broadcast value against its own entry and takes its own,
// its neighbor's or the new value in the same edge, whatever the fill level.
// The result register decouples the two sides; while it holds an untaken
// result and out_stall is high, in_stall is raised and nothing is accepted.
// Reset (rst_n low, synchronous) empties the store and drops any pending
// result; entry contents are left as they are and are never read unoccupied.
module insertion_sorted_store_core #(
  parameter int unsigned DEPTH = iss_pkg::ISS_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  iss_pkg::iss_in_req_t  in_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output iss_pkg::iss_out_req_t out_req
);
  import iss_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Fill count, kept alongside the cells' occupancy bits for full and empty.
  logic [CNT_W-1:0] count_r, count_nxt;

  logic         out_valid_r, out_valid_nxt;
  iss_out_req_t out_req_r, out_req_nxt;

  logic     in_fire;
  logic     full, empty;
  iss_cmd_t cmd;

  logic signed [ISS_DATA_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]             cell_occ;
  logic [DEPTH-1:0]             cell_gt;

  // A new request is taken whenever the result register is free or drains now.
  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    cmd.value = in_req.value;
    cmd.push  = in_fire && (in_req.op == ISS_OP_PUSH) && !full;
    cmd.pop   = in_fire && (in_req.op == ISS_OP_POP) && !empty;
  end

  // The chain: place zero holds the smallest entry. Pushes move larger
  // entries toward higher places, pops move everything toward place zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ISS_DATA_W-1:0] l_val, r_val;
    logic                         l_occ, l_gt, r_occ;

    if (i == 0) begin : g_first
      assign l_val = cmd.value;
      assign l_occ = 1'b1;
      assign l_gt  = 1'b0;
    end else begin : g_mid
      assign l_val = cell_val[i-1];
      assign l_occ = cell_occ[i-1];
      assign l_gt  = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign r_val = cmd.value;
      assign r_occ = 1'b0;
    end else begin : g_inner
      assign r_val = cell_val[i+1];
      assign r_occ = cell_occ[i+1];
    end

    iss_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_val  (l_val),
      .left_occ  (l_occ),
      .left_gt   (l_gt),
      .right_val (r_val),
      .right_occ (r_occ),
      .val       (cell_val[i]),
      .occ       (cell_occ[i]),
      .gt        (cell_gt[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Result for the request accepted this cycle.
  always_comb begin
    out_req_nxt              = out_req_r;
    out_req_nxt.sorted_value = '0;
    out_req_nxt.last         = 1'b0;
    out_req_nxt.status       = ISS_ST_OK;
    if (in_req.op == ISS_OP_PUSH) begin
      if (full) begin
        out_req_nxt.status = ISS_ST_FULL;
      end
    end else if (empty) begin
      out_req_nxt.status = ISS_ST_EMPTY;
    end else begin
      out_req_nxt.sorted_value = cell_val[0];
      out_req_nxt.last         = (count_r == CNT_W'(1));
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_req_r <= out_req_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  // The occupancy bits are the fill count in unary form.
  a_occ_count : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_occ) == int'(count_r))
    else $error("cell occupancy disagrees with fill count");

  // The lowest two places are always in order when both are filled.
  a_order : assert property (@(posedge clk) disable iff (!rst_n)
    (cell_occ[0] && cell_occ[1]) |-> (cell_val[0] <= cell_val[1]))
    else $error("chain out of order at its head");

  // A successful pop shrinks the store by exactly one entry.
  a_pop_count : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop did not remove exactly one entry");

  // A result that is not taken stays in place and blocks new requests.
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !in_fire)
    else $error("request accepted over an untaken result");

endmodule
